[rtl/ghrc_pkg.sv]
// Shared types and constants of the grouped histogram range count block.
`default_nettype none

package ghrc_pkg;

    localparam int CMD_W  = 2;
    localparam int GC_W   = 3;
    localparam int CNT_W  = 4;
    localparam int SUM_W  = 9;
    localparam int FREQ_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_AND  = 2'd1,
        CMD_OR   = 2'd2,
        CMD_AVG  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             query_start;
        logic             load_total;
        logic             beat_valid;
        logic [CNT_W-1:0] beat_k;
        logic [SUM_W-1:0] beat_s;
        logic             out_load;
    } t_acc_ctl;

endpackage

`default_nettype wire

[rtl/ghrc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ghrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ghrc_ctrl.sv]
// Sequencer for the clearing pass, cell loads and the table scan of a query.
`default_nettype none

module ghrc_ctrl #(
    parameter int MAX_GROUP_COUNT = 7,
    parameter int MAX_GROUP_SUM   = 350,
    parameter int SUM_SLOTS       = 512,
    parameter int ADDR_W          = $clog2((MAX_GROUP_COUNT + 1) * SUM_SLOTS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ghrc_pkg::CMD_W-1:0]        i_cmd,
    input  logic [ghrc_pkg::GC_W-1:0]         i_group_count,
    input  logic [ghrc_pkg::SUM_W-1:0]        i_group_sum,
    input  logic                              i_out_free,
    output ghrc_pkg::t_acc_ctl                o_ctl,
    output logic                              o_mem_we,
    output logic                              o_mem_wzero,
    output logic [ADDR_W-1:0]                 o_mem_waddr,
    output logic                              o_mem_re,
    output logic [ADDR_W-1:0]                 o_mem_raddr
);

    import ghrc_pkg::*;

    localparam int ROWS  = MAX_GROUP_COUNT + 1;
    localparam int DEPTH = ROWS * SUM_SLOTS;
    localparam logic [SUM_W-1:0] SUM_TOP =
        SUM_W'((MAX_GROUP_SUM < SUM_SLOTS) ? MAX_GROUP_SUM : SUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  K_TOP   = CNT_W'(MAX_GROUP_COUNT);
    localparam logic [ADDR_W-1:0] CLR_TOP = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] SLOT_A  = ADDR_W'(SUM_SLOTS);

    t_state           r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_k, n_k;
    logic [SUM_W-1:0] r_s, n_s;
    logic             r_beat_valid;
    logic [CNT_W-1:0] r_beat_k;
    logic [SUM_W-1:0] r_beat_s;

    t_cmd cmd;
    logic accept;
    logic is_load;
    logic load_ok;
    logic scan_last;

    assign cmd       = t_cmd'(i_cmd);
    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign is_load   = (cmd == CMD_LOAD);
    assign load_ok   = ({1'b0, i_group_count} <= K_TOP) && (i_group_sum <= SUM_TOP);
    assign scan_last = (r_k == K_TOP) && (r_s == SUM_TOP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_TOP) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && !is_load) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_mem_we          = 1'b0;
        o_mem_wzero       = 1'b0;
        o_mem_waddr       = ADDR_W'(i_group_count) * SLOT_A + ADDR_W'(i_group_sum);
        o_mem_re          = (r_state == ST_SCAN);
        o_mem_raddr       = ADDR_W'(r_k) * SLOT_A + ADDR_W'(r_s);
        o_ctl.query_start = 1'b0;
        o_ctl.load_total  = 1'b0;
        o_ctl.beat_valid  = r_beat_valid;
        o_ctl.beat_k      = r_beat_k;
        o_ctl.beat_s      = r_beat_s;
        o_ctl.out_load    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_wzero = 1'b1;
                o_mem_waddr = r_clr;
            end
            ST_IDLE: begin
                o_mem_we          = accept && is_load && load_ok;
                o_ctl.load_total  = accept && is_load && load_ok;
                o_ctl.query_start = accept && !is_load;
            end
            ST_DONE: begin
                o_ctl.out_load = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_clr = r_clr + ADDR_W'(1);
        n_k   = r_k;
        n_s   = r_s;
        if (r_state == ST_IDLE) begin
            n_k = CNT_W'(1);
            n_s = '0;
        end else if (r_state == ST_SCAN) begin
            if (r_s == SUM_TOP) begin
                n_s = '0;
                n_k = r_k + CNT_W'(1);
            end else begin
                n_s = r_s + SUM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_beat_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_beat_valid <= (r_state == ST_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_s      <= n_s;
        r_beat_k <= r_k;
        r_beat_s <= r_s;
    end

    a_beat_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_valid |-> $past(r_state == ST_SCAN))
        else $error("Read data tagged valid without a scan read issued.");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k != '0) && (r_k <= K_TOP) && (r_s <= SUM_TOP))
        else $error("Scan address left the populated part of the table.");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !r_beat_valid)
        else $error("Result offered while read data is still in flight.");

endmodule

`default_nettype wire

[rtl/ghrc_accum.sv]
// Per-count totals, query predicate, saturating accumulator and result register.
`default_nettype none

module ghrc_accum #(
    parameter int MAX_GROUP_COUNT = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ghrc_pkg::t_acc_ctl           i_ctl,
    input  logic [ghrc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ghrc_pkg::GC_W-1:0]    i_group_count,
    input  logic [ghrc_pkg::FREQ_W-1:0]  i_frequency,
    input  logic [ghrc_pkg::SUM_W-1:0]   i_low_bound,
    input  logic [ghrc_pkg::SUM_W-1:0]   i_high_bound,
    input  logic [ghrc_pkg::CNT_W-1:0]   i_count_low,
    input  logic [ghrc_pkg::CNT_W-1:0]   i_count_high,
    input  logic [ghrc_pkg::FREQ_W-1:0]  i_rdata,
    output logic                         o_out_free,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ghrc_pkg::FREQ_W-1:0]  o_cardinality
);

    import ghrc_pkg::*;

    localparam int ROWS  = MAX_GROUP_COUNT + 1;
    localparam int KW    = $clog2(ROWS);
    localparam int PRD_W = SUM_W + CNT_W;

    logic [FREQ_W-1:0] r_totals [ROWS];
    t_cmd              r_cmd;
    logic [SUM_W-1:0]  r_lo, r_hi;
    logic [CNT_W-1:0]  r_cl, r_ch;
    logic [FREQ_W-1:0] r_acc, n_acc;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_cardinality;

    logic [KW-1:0]     ld_idx;
    logic [KW-1:0]     rd_idx;
    logic [FREQ_W:0]   tot_sum;
    logic              in_k, in_s, in_avg;
    logic [PRD_W-1:0]  avg_lo, avg_hi, s_ext;
    logic [FREQ_W-1:0] addend;
    logic [FREQ_W:0]   acc_sum;

    assign ld_idx  = KW'(i_group_count);
    assign rd_idx  = i_ctl.beat_k[KW-1:0];
    assign tot_sum = {1'b0, r_totals[ld_idx]} + {1'b0, i_frequency};

    assign in_k   = (i_ctl.beat_k >= r_cl) && (i_ctl.beat_k <= r_ch);
    assign in_s   = (i_ctl.beat_s >= r_lo) && (i_ctl.beat_s <= r_hi);
    assign avg_lo = PRD_W'(r_lo) * PRD_W'(i_ctl.beat_k);
    assign avg_hi = PRD_W'(r_hi) * PRD_W'(i_ctl.beat_k);
    assign s_ext  = PRD_W'(i_ctl.beat_s);
    assign in_avg = (avg_lo <= s_ext) && (s_ext <= avg_hi);

    always_comb begin
        addend = '0;
        unique case (r_cmd)
            CMD_AND: begin
                if (in_k && in_s) begin
                    addend = i_rdata;
                end
            end
            CMD_OR: begin
                if (in_k) begin
                    if (i_ctl.beat_s == '0) begin
                        addend = r_totals[rd_idx];
                    end
                end else if (in_s) begin
                    addend = i_rdata;
                end
            end
            CMD_AVG: begin
                if (in_k && in_avg) begin
                    addend = i_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    assign acc_sum = {1'b0, r_acc} + {1'b0, addend};

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.query_start) begin
            n_acc = '0;
        end else if (i_ctl.beat_valid) begin
            n_acc = acc_sum[FREQ_W] ? '1 : acc_sum[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_totals[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.load_total) begin
                r_totals[ld_idx] <= tot_sum[FREQ_W] ? '1 : tot_sum[FREQ_W-1:0];
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctl.query_start) begin
            r_cmd <= t_cmd'(i_cmd);
            r_lo  <= i_low_bound;
            r_hi  <= i_high_bound;
            r_cl  <= i_count_low;
            r_ch  <= i_count_high;
        end
        if (i_ctl.out_load) begin
            r_cardinality <= r_acc;
        end
    end

    assign o_out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cardinality = r_cardinality;

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> o_out_free)
        else $error("Result register loaded while it still holds an untaken item.");

    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc == '1) && i_ctl.beat_valid && !i_ctl.query_start |=> (r_acc == '1))
        else $error("Saturated accumulator dropped below the maximum.");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_total |=> (r_totals[$past(ld_idx)] >= $past(r_totals[ld_idx])))
        else $error("Count total decreased on a load.");

endmodule

`default_nettype wire

[rtl/grouped_histogram_range_count_core.sv]
// Top level of the grouped histogram range count block.
//
// Input channel i_in_valid / o_in_ready carries one item: a cell load or a query.
// A load writes the cell (row count, sum) and adds its frequency to the count's
// running total if its sum is at most S, and returns no item. S, the top
// populated sum, is the smaller of MAX_GROUP_SUM and SUM_SLOTS - 1. A query
// scans every table cell of row counts 1 to MAX_GROUP_COUNT and sums 0 to S,
// one memory read per cycle, and returns one item with the cardinality. No
// new item is accepted until the query has passed the scan, drain and done
// states; the single read port of the table memory makes the scan go cell by cell.
// Output channel o_out_valid / i_out_ready is fed from a result register, so
// loads keep being accepted while a result waits. A query that finishes while
// the previous result is still untaken holds in its final state until the
// register frees up.
// After reset the table memory is swept to zero, one entry per cycle, over all
// (MAX_GROUP_COUNT + 1) * SUM_SLOTS entries (4096 by default); o_in_ready stays
// low during that sweep. The count totals are cleared by reset at once.
`default_nettype none

module grouped_histogram_range_count_core #(
    parameter int MAX_GROUP_COUNT = 7,
    parameter int MAX_GROUP_SUM   = 350,
    parameter int SUM_SLOTS       = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ghrc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ghrc_pkg::GC_W-1:0]    i_group_count,
    input  logic [ghrc_pkg::SUM_W-1:0]   i_group_sum,
    input  logic [ghrc_pkg::FREQ_W-1:0]  i_frequency,
    input  logic [ghrc_pkg::SUM_W-1:0]   i_low_bound,
    input  logic [ghrc_pkg::SUM_W-1:0]   i_high_bound,
    input  logic [ghrc_pkg::CNT_W-1:0]   i_count_low,
    input  logic [ghrc_pkg::CNT_W-1:0]   i_count_high,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ghrc_pkg::FREQ_W-1:0]  o_cardinality
);

    import ghrc_pkg::*;

    localparam int DEPTH  = (MAX_GROUP_COUNT + 1) * SUM_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_acc_ctl          ctl;
    logic              out_free;
    logic              mem_we, mem_wzero, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [FREQ_W-1:0] mem_wdata, mem_rdata;

    assign mem_wdata = mem_wzero ? '0 : i_frequency;

    ghrc_ctrl #(
        .MAX_GROUP_COUNT (MAX_GROUP_COUNT),
        .MAX_GROUP_SUM   (MAX_GROUP_SUM),
        .SUM_SLOTS       (SUM_SLOTS),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_group_count (i_group_count),
        .i_group_sum   (i_group_sum),
        .i_out_free    (out_free),
        .o_ctl         (ctl),
        .o_mem_we      (mem_we),
        .o_mem_wzero   (mem_wzero),
        .o_mem_waddr   (mem_waddr),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr)
    );

    ghrc_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ghrc_accum #(
        .MAX_GROUP_COUNT (MAX_GROUP_COUNT)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_cmd         (i_cmd),
        .i_group_count (i_group_count),
        .i_frequency   (i_frequency),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .i_count_low   (i_count_low),
        .i_count_high  (i_count_high),
        .i_rdata       (mem_rdata),
        .o_out_free    (out_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cardinality (o_cardinality)
    );

endmodule

`default_nettype wire

[tb/tb_grouped_histogram_range_count_core.sv]
// Self-checking testbench for the grouped histogram range count core.
`timescale 1ns / 1ps

import ghrc_pkg::*;

class cardinality_board;
    localparam int TOP_COUNT = 7;
    localparam int TOP_SUM   = 350;

    logic [FREQ_W-1:0] cells [0:TOP_COUNT][0:511];
    logic [FREQ_W-1:0] totals [0:TOP_COUNT];
    logic [FREQ_W-1:0] due_cards [$];
    int unsigned       mismatches;

    function new();
        foreach (cells[k, s]) cells[k][s] = '0;
        foreach (totals[k]) totals[k] = '0;
        mismatches = 0;
    endfunction

    function longint unsigned row_span(int k, int lo, int hi);
        longint unsigned acc;
        int top;
        acc = 0;
        top = (hi > TOP_SUM) ? TOP_SUM : hi;
        for (int s = lo; s <= top; s++) acc += cells[k][s];
        return acc;
    endfunction

    function void note_item(t_cmd cmd, logic [GC_W-1:0] gc, logic [SUM_W-1:0] gs,
                            logic [FREQ_W-1:0] fr, logic [SUM_W-1:0] lo,
                            logic [SUM_W-1:0] hi, logic [CNT_W-1:0] cl,
                            logic [CNT_W-1:0] ch);
        longint unsigned acc;
        longint unsigned sum_total;
        int lo_i, hi_i, cl_i, ch_i, kl, kh;
        acc = 0;
        lo_i = lo;
        hi_i = hi;
        cl_i = cl;
        ch_i = ch;
        if (cmd == CMD_LOAD) begin
            if (gs <= TOP_SUM) begin
                sum_total = totals[gc];
                sum_total += fr;
                cells[gc][gs] = fr;
                totals[gc] = (sum_total > 64'hFFFF_FFFF) ? '1 : sum_total[31:0];
            end
            return;
        end
        kl = (cl_i < 1) ? 1 : cl_i;
        kh = (ch_i > TOP_COUNT) ? TOP_COUNT : ch_i;
        case (cmd)
            CMD_AND: begin
                for (int k = kl; k <= kh; k++) acc += row_span(k, lo_i, hi_i);
            end
            CMD_OR: begin
                for (int k = 1; k <= TOP_COUNT; k++) begin
                    if (cl_i <= k && k <= ch_i) acc += totals[k];
                    else acc += row_span(k, lo_i, hi_i);
                end
            end
            default: begin
                for (int k = kl; k <= kh; k++) begin
                    for (int s = 0; s <= TOP_SUM; s++) begin
                        if (lo_i * k <= s && s <= hi_i * k) acc += cells[k][s];
                    end
                end
            end
        endcase
        due_cards.push_back((acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0]);
    endfunction

    function void check_cardinality(logic [FREQ_W-1:0] got);
        logic [FREQ_W-1:0] want;
        if (due_cards.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: cardinality %0d", got);
            return;
        end
        want = due_cards.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("cardinality mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module tb_grouped_histogram_range_count_core;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_cmd         = '0;
    logic [GC_W-1:0]   i_group_count = '0;
    logic [SUM_W-1:0]  i_group_sum   = '0;
    logic [FREQ_W-1:0] i_frequency   = '0;
    logic [SUM_W-1:0]  i_low_bound   = '0;
    logic [SUM_W-1:0]  i_high_bound  = '0;
    logic [CNT_W-1:0]  i_count_low   = '0;
    logic [CNT_W-1:0]  i_count_high  = '0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic [FREQ_W-1:0] o_cardinality;

    bit steady = 1'b0;
    cardinality_board board = new();

    grouped_histogram_range_count_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_group_count (i_group_count),
        .i_group_sum   (i_group_sum),
        .i_frequency   (i_frequency),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .i_count_low   (i_count_low),
        .i_count_high  (i_count_high),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cardinality (o_cardinality)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_cardinality(o_cardinality);
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [GC_W-1:0] gc,
                             input logic [SUM_W-1:0] gs, input logic [FREQ_W-1:0] fr,
                             input logic [SUM_W-1:0] lo, input logic [SUM_W-1:0] hi,
                             input logic [CNT_W-1:0] cl, input logic [CNT_W-1:0] ch);
        if (!steady && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (!steady && $urandom_range(0, 99) < 34) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_group_count <= gc;
        i_group_sum   <= gs;
        i_frequency   <= fr;
        i_low_bound   <= lo;
        i_high_bound  <= hi;
        i_count_low   <= cl;
        i_count_high  <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(cmd, gc, gs, fr, lo, hi, cl, ch);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.due_cards.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_cmd              cmd;
        logic [GC_W-1:0]   gc;
        logic [SUM_W-1:0]  gs;
        logic [FREQ_W-1:0] fr;
        logic [SUM_W-1:0]  lo;
        logic [SUM_W-1:0]  hi;
        logic [CNT_W-1:0]  cl;
        logic [CNT_W-1:0]  ch;
        int                pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_AND,  3'd0, 9'd0,   32'd0,          9'd0,   9'd511, 4'd0,  4'd15);
        send_item(CMD_LOAD, 3'd1, 9'd0,   32'd5,          9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd7, 9'd350, 32'hFFFF_FFFF,  9'd511, 9'd511, 4'd15, 4'd15);
        send_item(CMD_LOAD, 3'd0, 9'd10,  32'd100,        9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd3, 9'd351, 32'd77,         9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd3, 9'd511, 32'd9,          9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd2, 9'd20,  32'd10,         9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd2, 9'd20,  32'd3,          9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd7, 9'd349, 32'hFFFF_FFFF,  9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_LOAD, 3'd4, 9'd200, 32'd1000,       9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_AND,  3'd7, 9'd511, 32'hFFFF_FFFF,  9'd0,   9'd511, 4'd0,  4'd15);
        send_item(CMD_AND,  3'd0, 9'd0,   32'd0,          9'd0,   9'd300, 4'd0,  4'd15);
        send_item(CMD_AND,  3'd0, 9'd0,   32'd0,          9'd30,  9'd10,  4'd0,  4'd15);
        send_item(CMD_AND,  3'd0, 9'd0,   32'd0,          9'd0,   9'd511, 4'd15, 4'd0);
        send_item(CMD_OR,   3'd0, 9'd0,   32'd0,          9'd0,   9'd0,   4'd2,  4'd2);
        send_item(CMD_OR,   3'd0, 9'd0,   32'd0,          9'd511, 9'd511, 4'd0,  4'd15);
        send_item(CMD_OR,   3'd0, 9'd0,   32'd0,          9'd0,   9'd511, 4'd15, 4'd15);
        send_item(CMD_AVG,  3'd0, 9'd0,   32'd0,          9'd0,   9'd511, 4'd0,  4'd15);
        send_item(CMD_AVG,  3'd0, 9'd0,   32'd0,          9'd50,  9'd50,  4'd7,  4'd7);
        send_item(CMD_AVG,  3'd0, 9'd0,   32'd0,          9'd10,  9'd10,  4'd2,  4'd2);
        send_item(CMD_AVG,  3'd0, 9'd0,   32'd0,          9'd511, 9'd511, 4'd1,  4'd7);
        send_item(CMD_AND,  3'd0, 9'd0,   32'd0,          9'd350, 9'd350, 4'd7,  4'd7);
        send_item(CMD_LOAD, 3'd7, 9'd350, 32'd0,          9'd0,   9'd0,   4'd0,  4'd0);
        send_item(CMD_AVG,  3'd0, 9'd0,   32'd0,          9'd50,  9'd50,  4'd7,  4'd7);
        wait_drained();

        for (int n = 0; n < 240; n++) begin
            steady = (n >= 100 && n < 160);
            if (n == 130) wait_drained();
            lo = SUM_W'($urandom());
            hi = SUM_W'($urandom());
            cl = CNT_W'($urandom());
            ch = CNT_W'($urandom());
            gc = GC_W'($urandom());
            gs = SUM_W'($urandom());
            fr = $urandom();
            if ($urandom_range(0, 99) < 64) begin
                cmd = CMD_LOAD;
                if ($urandom_range(0, 9) != 0) gs = SUM_W'($urandom_range(0, 350));
                pick = $urandom_range(0, 39);
                if (pick == 0) fr = '1;
                else if (pick > 2) fr = $urandom_range(0, 4095);
            end else begin
                cmd = t_cmd'($urandom_range(1, 3));
                if ($urandom_range(0, 4) != 0) begin
                    if (cmd == CMD_AVG) begin
                        lo = SUM_W'($urandom_range(0, 60));
                        hi = SUM_W'(lo + $urandom_range(0, 40));
                    end else begin
                        lo = SUM_W'($urandom_range(0, 350));
                        hi = SUM_W'(lo + $urandom_range(0, 160));
                    end
                    cl = CNT_W'($urandom_range(0, 7));
                    ch = CNT_W'(cl + $urandom_range(0, 8));
                end
            end
            send_item(cmd, gc, gs, fr, lo, hi, cl, ch);
        end
        steady = 1'b0;
        wait_drained();
        repeat (2600) @(posedge i_clk);

        if (board.mismatches == 0 && board.due_cards.size() == 0) begin
            $display("grouped_histogram_range_count_core verification clean");
        end else begin
            $display("grouped_histogram_range_count_core verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("grouped_histogram_range_count_core verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/ghrc_pkg.sv
rtl/ghrc_ram.sv
rtl/ghrc_ctrl.sv
rtl/ghrc_accum.sv
rtl/grouped_histogram_range_count_core.sv
tb/tb_grouped_histogram_range_count_core.sv
